/* rtl/core/per_slot_running_stats_unit_defines.svh */
// ----------------------------------------------------------------------------
// per_slot_running_stats_unit_defines
// Assertion macros for the running statistics unit.
// ----------------------------------------------------------------------------
`ifndef PER_SLOT_RUNNING_STATS_UNIT_DEFINES_SVH
`define PER_SLOT_RUNNING_STATS_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PSRS_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// next-cycle implication
`define PSRS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

/* rtl/core/psrs_pkg.sv */
// ----------------------------------------------------------------------------
// psrs_pkg
// Types and constants shared by the running statistics unit.
// ----------------------------------------------------------------------------
package psrs_pkg;
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
   localparam logic [47:0] M48     = 48'hFFFF_FFFF_FFFF;
   localparam logic [62:0] SQ_MAX  = {63{1'b1}};

   typedef struct packed {
      logic [31:0] count;
      logic [47:0] total;
      logic [31:0] maxv;
      logic [47:0] mean;
      logic [62:0] sqdev;
   } entry_type;
endpackage

/* rtl/core/psrs_req_if.sv */
// ----------------------------------------------------------------------------
// psrs_req_if
// Request channel: slot and elapsed time.
// ----------------------------------------------------------------------------
interface psrs_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  slot;
   logic [31:0] elapsed_us;
   modport source (output valid, slot, elapsed_us, input ready);
   modport sink   (input valid, slot, elapsed_us, output ready);
endinterface

/* rtl/core/psrs_rsp_if.sv */
// ----------------------------------------------------------------------------
// psrs_rsp_if
// Response channel: updated statistics of one slot.
// ----------------------------------------------------------------------------
interface psrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] call_count;
   logic [47:0] total_us;
   logic [31:0] max_us;
   logic [47:0] mean_us;
   logic [62:0] sq_dev_sum;
   modport source (output valid, call_count, total_us, max_us, mean_us, sq_dev_sum,
                   input ready);
   modport sink   (input valid, call_count, total_us, max_us, mean_us, sq_dev_sum,
                   output ready);
endinterface

/* rtl/core/psrs_div.sv */
// ----------------------------------------------------------------------------
// psrs_div
// Restoring divider, one quotient bit per cycle: 64-bit dividend / 32-bit divisor.
// ----------------------------------------------------------------------------
module psrs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      trial   = {rem_ff[31:0], quo_ff[63]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/core/psrs_mul.sv */
// ----------------------------------------------------------------------------
// psrs_mul
// 48 x 48 multiplier over four 24 x 24 partial products, one per cycle.
// ----------------------------------------------------------------------------
module psrs_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] a,
   input  logic [47:0] b,
   output logic        done,
   output logic [95:0] product
);
   logic [47:0] a_ff, b_ff;
   logic [95:0] acc_ff, acc_in;
   logic [2:0]  step_ff, step_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [23:0] pa, pb;
   logic [47:0] pp_ff;
   logic [95:0] shifted;

   always_comb begin
      pa = step_ff[1] ? a_ff[47:24] : a_ff[23:0];
      pb = step_ff[0] ? b_ff[47:24] : b_ff[23:0];
   end

   // step k multiplies, step k+1 accumulates the registered product of step k
   always_comb begin
      case ({step_ff[2:0] - 3'd1})
         3'd0:    shifted = {48'd0, pp_ff};
         3'd1:    shifted = {24'd0, pp_ff, 24'd0};
         3'd2:    shifted = {24'd0, pp_ff, 24'd0};
         3'd3:    shifted = {pp_ff, 48'd0};
         default: shifted = '0;
      endcase
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         step_in = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff != 3'd0) acc_in = acc_ff + shifted;
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
      pp_ff  <= pa * pb;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

/* rtl/core/per_slot_running_stats_unit.sv */
// ----------------------------------------------------------------------------
// per_slot_running_stats_unit
// Per-slot running statistics with Welford sum of squared deviations.
// ----------------------------------------------------------------------------
// Usage:
//  req (slot, elapsed_us) updates one slot; rsp returns the slot's updated
//  call count, total, maximum, Q32.16 mean and Q47.16 squared-deviation sum.
//  Slots at or above SLOTS leave the table untouched and return all zeros.
//  One transaction is in flight at a time; req_ready is high only when idle.
//  From the accepting edge to rsp_valid: the table read is issued at accept,
//  then a bit-serial divide forms the mean, a partial-product multiply forms
//  the deviation product, then the entry is written back.
//  Reset starts a clearing pass of SLOTS cycles through the table memory,
//  during which req_ready stays low.
//  A stalled rsp holds its payload; the next request waits until it is taken.
// ----------------------------------------------------------------------------
`include "per_slot_running_stats_unit_defines.svh"
module per_slot_running_stats_unit #(
   parameter int SLOTS = 64
) (
   input  logic clock,
   input  logic reset,
   psrs_req_if.sink   req,
   psrs_rsp_if.source rsp
);
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_RSP   = 3'd6;

   psrs_pkg::entry_type mem [SLOTS];
   psrs_pkg::entry_type rd_ff, res_ff, res_in;

   logic [2:0]    state_ff, state_in;
   logic [AW:0]   clr_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] slot_idx, rd_addr;
   logic [31:0]   x_ff;
   logic [31:0]   cnt_c;
   logic [47:0]   tot_c;
   logic [47:0]   d1_ff;
   logic          n1_ff;
   logic [47:0]   d2_c;
   logic          n2_c;

   logic          div_start, div_done, mul_start, mul_done;
   logic [63:0]   quotient;
   logic [95:0]   product;
   logic [47:0]   mean_c, x16;
   logic [32:0]   cnt_p1;
   logic [48:0]   tot_sum;
   logic [62:0]   inc;
   logic [63:0]   sq_sum;
   logic          in_range;

   assign x16      = {x_ff, 16'd0};
   assign in_range = ({26'd0, req.slot} < 32'(SLOTS));
   assign slot_idx = AW'({26'd0, req.slot});
   assign cnt_p1   = {1'b0, rd_ff.count} + 33'd1;
   assign tot_sum  = {1'b0, rd_ff.total} + {17'd0, x_ff};
   assign cnt_c    = cnt_p1[32] ? psrs_pkg::CNT_MAX : cnt_p1[31:0];
   assign tot_c    = tot_sum[48] ? psrs_pkg::M48 : tot_sum[47:0];
   assign mean_c   = (quotient[63:48] != 16'd0) ? psrs_pkg::M48 : quotient[47:0];

   always_comb begin
      if (x16 >= mean_c) begin
         d2_c = x16 - mean_c;
         n2_c = 1'b0;
      end else begin
         d2_c = mean_c - x16;
         n2_c = 1'b1;
      end
   end

   assign div_start = (state_ff == ST_READ);
   assign mul_start = (state_ff == ST_DIV) && div_done;

   psrs_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend({tot_c, 16'd0}),
      .divisor(cnt_c), .done(div_done), .quotient(quotient)
   );

   psrs_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(d1_ff), .b(d2_c), .done(mul_done), .product(product)
   );

   logic n2_ff;

   always_comb begin
      inc = (product[95:79] != 17'd0) ? psrs_pkg::SQ_MAX : product[78:16];
      sq_sum = {1'b0, res_ff.sqdev} + {1'b0, inc};
   end

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == (AW + 1)'(SLOTS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req.valid) begin
               if (in_range) begin
                  state_in = ST_READ;
               end else begin
                  res_in   = '0;
                  state_in = ST_RSP;
               end
            end
         end
         ST_READ:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               res_in.mean = mean_c;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               if (n1_ff != n2_ff) begin
                  res_in.sqdev = (res_ff.sqdev >= inc) ? res_ff.sqdev - inc : '0;
               end else begin
                  res_in.sqdev = sq_sum[63] ? psrs_pkg::SQ_MAX : sq_sum[62:0];
               end
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_RSP;
         ST_RSP:   if (rsp.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
      // gather the simple fields once the table entry has arrived
      if (state_ff == ST_READ) begin
         res_in.count = cnt_c;
         res_in.total = tot_c;
         res_in.maxv  = (x_ff > rd_ff.maxv) ? x_ff : rd_ff.maxv;
         res_in.sqdev = rd_ff.sqdev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
      end
      res_ff <= res_in;
      if (state_ff == ST_IDLE && req.valid) begin
         addr_ff <= slot_idx;
         x_ff    <= req.elapsed_us;
      end
      if (state_ff == ST_READ) begin
         if (x16 >= rd_ff.mean) begin
            d1_ff <= x16 - rd_ff.mean;
            n1_ff <= 1'b0;
         end else begin
            d1_ff <= rd_ff.mean - x16;
            n1_ff <= 1'b1;
         end
      end
      if (mul_start) n2_ff <= n2_c;
   end

   // issue the read with the incoming slot while idle so the entry is
   // already registered during ST_READ
   assign rd_addr = (state_ff == ST_IDLE) ? slot_idx : addr_ff;

   // table memory: one read, one write port
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         mem[clr_ff[AW-1:0]] <= '0;
      end else if (state_ff == ST_WRITE) begin
         mem[addr_ff] <= res_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = (state_ff == ST_RSP);
   assign rsp.call_count = res_ff.count;
   assign rsp.total_us   = res_ff.total;
   assign rsp.max_us     = res_ff.maxv;
   assign rsp.mean_us    = res_ff.mean;
   assign rsp.sq_dev_sum = res_ff.sqdev;

   `PSRS_ASSERT_IMP(a_ready_not_rsp, clock, reset, rsp.valid, !req.ready)
   `PSRS_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.call_count))
   `PSRS_ASSERT_IMP(a_one_unit, clock, reset, div_start, !mul_start)
endmodule

/* tb/tb_per_slot_running_stats_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_slot_running_stats_unit
// Drives slot/elapsed-time transactions into the running statistics unit and
// checks every response against an in-bench model of the per-slot table.
// ----------------------------------------------------------------------------

class stats_scoreboard;
   typedef struct packed {
      logic [31:0] count;
      logic [47:0] total;
      logic [31:0] maxv;
      logic [47:0] mean;
      logic [62:0] sqdev;
   } stats_rec;

   int          slot_limit;
   bit [31:0]   cnt_tab  [];
   bit [47:0]   tot_tab  [];
   bit [31:0]   max_tab  [];
   bit [47:0]   mean_tab [];
   bit [62:0]   sq_tab   [];
   stats_rec    pending  [$];
   int          errors;
   int          checked;

   function new(int slots);
      slot_limit = slots;
      cnt_tab  = new[slots];
      tot_tab  = new[slots];
      max_tab  = new[slots];
      mean_tab = new[slots];
      sq_tab   = new[slots];
      foreach (cnt_tab[i]) begin
         cnt_tab[i] = 0; tot_tab[i] = 0; max_tab[i] = 0;
         mean_tab[i] = 0; sq_tab[i] = 0;
      end
      errors = 0;
      checked = 0;
   endfunction

   // update the slot and queue the statistics it should report
   function void note_request(bit [5:0] slot, bit [31:0] x);
      stats_rec    r;
      bit [32:0]   cnt;
      bit [48:0]   tot;
      bit [80:0]   quo;
      bit [47:0]   new_mean, old_mean;
      bit [47:0]   x16;
      bit [47:0]   d1, d2;
      bit [95:0]   prod;
      bit [79:0]   inc;
      bit [63:0]   sq;
      bit          n1, n2;
      if (slot >= slot_limit) begin
         r = '0;
         pending.push_back(r);
         return;
      end
      cnt = cnt_tab[slot];
      if (cnt < 33'hFFFF_FFFF) cnt++;
      tot = tot_tab[slot] + x;
      if (tot > 49'hFFFF_FFFF_FFFF) tot = 49'hFFFF_FFFF_FFFF;
      old_mean = mean_tab[slot];
      quo = ({32'd0, tot} << 16) / cnt;
      new_mean = (quo > 81'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : quo[47:0];
      x16 = {x, 16'd0};
      n1 = x16 < old_mean;
      d1 = n1 ? old_mean - x16 : x16 - old_mean;
      n2 = x16 < new_mean;
      d2 = n2 ? new_mean - x16 : x16 - new_mean;
      prod = d1 * d2;
      inc = prod[95:16];
      if (inc > {17'd0, {63{1'b1}}}) inc = {17'd0, {63{1'b1}}};
      sq = sq_tab[slot];
      if (n1 != n2) sq = (sq >= inc) ? sq - inc : 0;
      else begin
         sq = sq + inc;
         if (sq > {1'b0, {63{1'b1}}}) sq = {1'b0, {63{1'b1}}};
      end
      cnt_tab[slot]  = cnt[31:0];
      tot_tab[slot]  = tot[47:0];
      if (x > max_tab[slot]) max_tab[slot] = x;
      mean_tab[slot] = new_mean;
      sq_tab[slot]   = sq[62:0];
      r.count = cnt[31:0]; r.total = tot[47:0]; r.maxv = max_tab[slot];
      r.mean = new_mean; r.sqdev = sq[62:0];
      pending.push_back(r);
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %0s: got %h expected %h (response %0d)", what, got, want, checked);
      errors++;
   endtask

   task check_response(logic [31:0] c, logic [47:0] t, logic [31:0] m,
                       logic [47:0] mu, logic [62:0] s);
      stats_rec w;
      if (pending.size() == 0) begin
         $display("unexpected response with nothing outstanding");
         errors++;
         return;
      end
      w = pending.pop_front();
      if (c !== w.count) report("call_count", c, w.count);
      if (t !== w.total) report("total_us", t, w.total);
      if (m !== w.maxv) report("max_us", m, w.maxv);
      if (mu !== w.mean) report("mean_us", mu, w.mean);
      if (s !== w.sqdev) report("sq_dev_sum", s, w.sqdev);
      checked++;
   endtask
endclass

module tb_per_slot_running_stats_unit;
   localparam int SLOTS = 64;
   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;

   psrs_req_if req ();
   psrs_rsp_if rsp ();

   per_slot_running_stats_unit #(.SLOTS(SLOTS)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   stats_scoreboard sb;
   int  sent;
   int  idle_cycles;
   bit  long_hold;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // sample both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) sb.note_request(req.slot, req.elapsed_us);
         if (rsp.valid && rsp.ready)
            sb.check_response(rsp.call_count, rsp.total_us, rsp.max_us,
                              rsp.mean_us, rsp.sq_dev_sum);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int k;
      bit rdy;
      rsp.ready = 0;
      @(negedge clock);
      while (1) begin
         if (long_hold) begin
            rsp.ready <= 0;
            for (k = 0; k < 600; k++) @(negedge clock);
            long_hold = 0;
         end
         rdy = ($urandom_range(0, 3) != 0) || ($urandom_range(0, 15) == 0);
         rsp.ready <= rdy;
         @(negedge clock);
      end
   end

   task send_one(bit [5:0] slot, bit [31:0] x);
      req.valid      <= 1;
      req.slot       <= slot;
      req.elapsed_us <= x;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task pause_sender(int n);
      req.valid <= 0;
      repeat (n) @(negedge clock);
   endtask

   function bit [31:0] rand_time();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         2: return $urandom;
         default: return $urandom_range(0, 50000);
      endcase
   endfunction

   initial begin
      int b, n, burst;
      sb = new(SLOTS);
      sent = 0;
      idle_cycles = 0;
      long_hold = 0;
      req.valid = 0;
      req.slot = 0;
      req.elapsed_us = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, repeated slot, both ends of the slot range
      send_one(6'd0, 32'd0);
      send_one(6'd0, 32'd0);
      send_one(6'd63, 32'hFFFF_FFFF);
      send_one(6'd63, 32'hFFFF_FFFF);
      send_one(6'd63, 32'd0);
      send_one(6'd63, 32'd1);
      send_one(6'd1, 32'd100);
      send_one(6'd1, 32'd1);
      send_one(6'd1, 32'd7);
      send_one(6'd1, 32'd200);
      send_one(6'd2, 32'hAAAA_AAAA);
      send_one(6'd2, 32'h5555_5555);
      send_one(6'd21, 32'd3);
      send_one(6'd42, 32'd5);
      send_one(6'd42, 32'd4);
      send_one(6'd42, 32'd6);
      for (b = 0; b < 6; b++) send_one(6'd3, 32'hFFFF_FFFF);
      pause_sender(1);

      // wait for all outstanding responses to be checked
      while (sb.pending.size() != 0) @(negedge clock);
      long_hold = 1;

      // random bursts; most traffic hits a few hot slots
      n = 0;
      while (n < 950) begin
         burst = $urandom_range(1, 12);
         for (b = 0; b < burst; b++) begin
            if ($urandom_range(0, 3) == 0)
               send_one(6'($urandom_range(0, 63)), rand_time());
            else send_one(6'($urandom_range(0, 7)), rand_time());
            n++;
         end
         if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 200));
         if (n > 500 && n < 513) begin
            pause_sender(1);
            while (sb.pending.size() != 0) @(negedge clock);
         end
      end
      req.valid <= 0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("sent %0d transactions, checked %0d responses over all 64 slots",
               sent, sb.checked);
      $display("included saturating totals, long response hold-off and a full drain");
      if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/psrs_pkg.sv
rtl/core/psrs_req_if.sv
rtl/core/psrs_rsp_if.sv
rtl/core/psrs_div.sv
rtl/core/psrs_mul.sv
rtl/core/per_slot_running_stats_unit.sv
tb/tb_per_slot_running_stats_unit.sv
